@@ rtl/bprd_pkg.sv @@
package bprd_pkg;

    localparam int MAX_ROW_PIXELS_DEF  = 4096;
    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int ROW_WIDTH_W = 13;
    localparam int PIX_FMT_W   = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // bits per pixel codes
    localparam logic [PIX_FMT_W-1:0] FMT_1BPP  = 3'd0;
    localparam logic [PIX_FMT_W-1:0] FMT_2BPP  = 3'd1;
    localparam logic [PIX_FMT_W-1:0] FMT_4BPP  = 3'd2;
    localparam logic [PIX_FMT_W-1:0] FMT_8BPP  = 3'd3;
    localparam logic [PIX_FMT_W-1:0] FMT_16BPP = 3'd4;
    localparam logic [PIX_FMT_W-1:0] FMT_24BPP = 3'd5;
    localparam logic [PIX_FMT_W-1:0] FMT_32BPP = 3'd6;

    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_FORMAT = 3'd0,
        CFG_ROW_WIDTH    = 3'd1,
        CFG_RED_MASK     = 3'd2,
        CFG_GREEN_MASK   = 3'd3,
        CFG_BLUE_MASK    = 3'd4,
        CFG_ALPHA_MASK   = 3'd5
    } t_cfg_idx;

    localparam logic [PIX_FMT_W-1:0]   FORMAT_RST = FMT_24BPP;
    localparam logic [ROW_WIDTH_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [31:0] RED_MASK_RST   = 32'h00ff_0000;
    localparam logic [31:0] GREEN_MASK_RST = 32'h0000_ff00;
    localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00ff;
    localparam logic [31:0] ALPHA_MASK_RST = 32'h0000_0000;

    // trailing zero count, 31 for an all-zero mask
    function automatic logic [4:0] trail_zeros(input logic [31:0] mask);
        logic [4:0] cnt;
        cnt = 5'd31;
        for (int k = 31; k >= 0; k--) begin
            if (mask[k]) cnt = 5'(k);
        end
        return cnt;
    endfunction

    function automatic logic [7:0] chan(input logic [31:0] raw, input logic [31:0] mask,
                                        input logic [4:0] sh);
        logic [31:0] tmp;
        tmp = (raw & mask) >> sh;
        return tmp[7:0];
    endfunction

endpackage

@@ rtl/bmp_pixel_row_decoder_unit.sv @@
// channel  | dir | handshake                        | payload
// s_axis   | in  | i_s_axis_tvalid/o_s_axis_tready  | tdata: palette_slot, palette_word,
//          |     |                                  |   data_byte; tuser: req_type
// m_axis   | out | o_m_axis_tvalid/i_m_axis_tready  | tdata: red, green, blue, alpha;
//          |     |                                  |   tlast: row_end; tuser: run_last
// cfg      | in  | i_cfg_valid/o_cfg_ready          | i_cfg_index, i_cfg_data
//
// a palette write, a direct-format byte and an 8 bpp byte each take one step in the
// work register; a 1, 2 or 4 bpp byte takes one step per pixel it yields (at most 8, 4, 2).
// pixels pass from the work register into the output register; indexed pixels read
// the colour table through its single registered read port as they are loaded.
// output stalls hold the work register only when it has a pixel to hand over.
// reset is synchronous, active low, and restores the register defaults and row position.
module bmp_pixel_row_decoder_unit
    import bprd_pkg::*;
#(
    parameter int MAX_ROW_PIXELS  = MAX_ROW_PIXELS_DEF,
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // palette_slot [7:0], palette_word [39:8], data_byte [47:40]
    input  logic [47:0]           i_s_axis_tdata,
    // req_type
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // pixel_red [7:0], pixel_green [15:8], pixel_blue [23:16], pixel_alpha [31:24]
    output logic [31:0]           o_m_axis_tdata,
    output logic                  o_m_axis_tlast,
    // run_last
    output logic                  o_m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int W_PIX   = $clog2(MAX_ROW_PIXELS + 1);
    localparam int W_CNT   = (W_PIX > ROW_WIDTH_W) ? W_PIX : ROW_WIDTH_W;
    localparam int W_BYTES = W_CNT + 3;
    localparam int AW      = $clog2(PALETTE_ENTRIES);

    // configuration
    logic [PIX_FMT_W-1:0]   r_fmt;
    logic [ROW_WIDTH_W-1:0] r_row_width;
    logic [31:0] r_red_mask, r_green_mask, r_blue_mask, r_alpha_mask;
    logic [4:0]  r_red_sh, r_green_sh, r_blue_sh, r_alpha_sh;
    logic        cfg_we;
    logic        cfg_row_clr;

    // row position
    logic [23:0]        r_accum, n_accum;
    logic [1:0]         r_bip, n_bip;
    logic [W_CNT-1:0]   r_pix_done, n_pix_done;
    logic [W_BYTES-1:0] r_bytes_done, n_bytes_done;

    // work register
    logic       r_s1_valid;
    logic       r_s1_type;
    logic [7:0] r_s1_slot;
    logic [31:0] r_s1_word;
    logic [7:0] r_s1_byte;
    logic [2:0] r_s1_sub;

    // output register
    logic        r_out_valid;
    logic        r_out_ind;
    logic        r_out_zero;
    logic [31:0] r_out_direct;
    logic        r_out_row_end;
    logic        r_out_run_last;
    logic [31:0] r_rd_data;

    logic [31:0] r_pal_mem [PALETTE_ENTRIES];

    logic [W_CNT-1:0]   eff_w;
    logic [W_CNT-1:0]   pix_inc;
    logic [W_CNT+4:0]   row_bits;
    logic [W_CNT+5:0]   row_bits_pad;
    logic [W_BYTES-1:0] row_bytes;
    logic [W_BYTES-1:0] bytes_inc;
    logic       indexed, is_pix, has_pix, sub_last, row_last, px_full;
    logic [2:0] per_m1;
    logic [1:0] nb_m1;
    logic       emit, out_load_ok, s1_step, s1_done, byte_end, load_en;
    logic [2:0] idx_sh;
    logic [7:0] shifted;
    logic [7:0] pal_idx;
    logic       idx_oob;
    logic [31:0] raw;
    logic [31:0] direct_rgba;
    logic        pal_we;
    logic        rd_en;
    logic [31:0] pal_rgba;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_row_clr = cfg_we && (i_cfg_index == CFG_PIXEL_FORMAT ||
                                    i_cfg_index == CFG_ROW_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt        <= FORMAT_RST;
            r_row_width  <= WIDTH_RST;
            r_red_mask   <= RED_MASK_RST;
            r_green_mask <= GREEN_MASK_RST;
            r_blue_mask  <= BLUE_MASK_RST;
            r_alpha_mask <= ALPHA_MASK_RST;
            r_red_sh     <= trail_zeros(RED_MASK_RST);
            r_green_sh   <= trail_zeros(GREEN_MASK_RST);
            r_blue_sh    <= trail_zeros(BLUE_MASK_RST);
            r_alpha_sh   <= trail_zeros(ALPHA_MASK_RST);
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_PIXEL_FORMAT: r_fmt       <= i_cfg_data[PIX_FMT_W-1:0];
                CFG_ROW_WIDTH:    r_row_width <= i_cfg_data[ROW_WIDTH_W-1:0];
                CFG_RED_MASK: begin
                    r_red_mask <= i_cfg_data;
                    r_red_sh   <= trail_zeros(i_cfg_data);
                end
                CFG_GREEN_MASK: begin
                    r_green_mask <= i_cfg_data;
                    r_green_sh   <= trail_zeros(i_cfg_data);
                end
                CFG_BLUE_MASK: begin
                    r_blue_mask <= i_cfg_data;
                    r_blue_sh   <= trail_zeros(i_cfg_data);
                end
                CFG_ALPHA_MASK: begin
                    r_alpha_mask <= i_cfg_data;
                    r_alpha_sh   <= trail_zeros(i_cfg_data);
                end
                default: ;
            endcase
        end
    end

    // effective width and padded row length
    always_comb begin
        if (r_row_width == '0) begin
            eff_w = W_CNT'(1);
        end else if (W_CNT'(r_row_width) > W_CNT'(MAX_ROW_PIXELS)) begin
            eff_w = W_CNT'(MAX_ROW_PIXELS);
        end else begin
            eff_w = W_CNT'(r_row_width);
        end
        case (r_fmt)
            FMT_1BPP:  row_bits = (W_CNT+5)'(eff_w);
            FMT_2BPP:  row_bits = (W_CNT+5)'(eff_w) << 1;
            FMT_4BPP:  row_bits = (W_CNT+5)'(eff_w) << 2;
            FMT_8BPP:  row_bits = (W_CNT+5)'(eff_w) << 3;
            FMT_16BPP: row_bits = (W_CNT+5)'(eff_w) << 4;
            FMT_24BPP: row_bits = ((W_CNT+5)'(eff_w) << 4) + ((W_CNT+5)'(eff_w) << 3);
            default:   row_bits = (W_CNT+5)'(eff_w) << 5;
        endcase
        row_bits_pad = (W_CNT+6)'(row_bits) + (W_CNT+6)'(31);
        row_bytes    = {row_bits_pad[W_CNT+5:5], 2'b00};
    end

    // per step control of the work register
    always_comb begin
        indexed  = r_fmt <= FMT_8BPP;
        is_pix   = r_s1_type == REQ_PIXEL;
        has_pix  = r_pix_done < eff_w;
        pix_inc  = r_pix_done + W_CNT'(1);
        row_last = pix_inc == eff_w;
        per_m1   = 3'(3'd7 >> r_fmt[1:0]);
        sub_last = r_s1_sub == per_m1;
        case (r_fmt)
            FMT_16BPP: nb_m1 = 2'd1;
            FMT_24BPP: nb_m1 = 2'd2;
            default:   nb_m1 = 2'd3;
        endcase
        px_full     = r_bip >= nb_m1;
        emit        = r_s1_valid && is_pix && has_pix && (indexed || px_full);
        out_load_ok = !r_out_valid || i_m_axis_tready;
        s1_step     = r_s1_valid && (!emit || out_load_ok);
        s1_done     = s1_step && (!is_pix || !indexed || !has_pix || sub_last || row_last);
        byte_end    = s1_done && is_pix;
        load_en     = emit && out_load_ok;
    end

    assign o_s_axis_tready = !r_s1_valid || s1_done;

    // palette index, most significant bits first
    always_comb begin
        idx_sh  = 3'(r_s1_sub << r_fmt[1:0]);
        shifted = 8'(r_s1_byte << idx_sh);
        case (r_fmt[1:0])
            2'd0:    pal_idx = {7'd0, shifted[7]};
            2'd1:    pal_idx = {6'd0, shifted[7:6]};
            2'd2:    pal_idx = {4'd0, shifted[7:4]};
            default: pal_idx = shifted;
        endcase
        idx_oob = {1'b0, pal_idx} >= 9'(PALETTE_ENTRIES);
    end

    // direct formats: last byte joins the gathered ones
    always_comb begin
        raw = {8'd0, r_accum} | (32'(r_s1_byte) << {nb_m1, 3'b000});
        direct_rgba = {chan(raw, r_alpha_mask, r_alpha_sh),
                       chan(raw, r_blue_mask, r_blue_sh),
                       chan(raw, r_green_mask, r_green_sh),
                       chan(raw, r_red_mask, r_red_sh)};
    end

    always_comb begin
        n_accum      = r_accum;
        n_bip        = r_bip;
        n_pix_done   = r_pix_done;
        n_bytes_done = r_bytes_done;
        bytes_inc    = r_bytes_done + W_BYTES'(1);
        if (load_en) n_pix_done = pix_inc;
        if (s1_step && is_pix && !indexed && has_pix) begin
            if (px_full) begin
                n_accum = '0;
                n_bip   = '0;
            end else begin
                n_accum = r_accum | (24'(r_s1_byte) << {r_bip, 3'b000});
                n_bip   = r_bip + 2'd1;
            end
        end
        if (byte_end) begin
            if (bytes_inc >= row_bytes) begin
                n_accum      = '0;
                n_bip        = '0;
                n_pix_done   = '0;
                n_bytes_done = '0;
            end else begin
                n_bytes_done = bytes_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_row_clr) begin
            r_accum      <= '0;
            r_bip        <= '0;
            r_pix_done   <= '0;
            r_bytes_done <= '0;
        end else begin
            r_accum      <= n_accum;
            r_bip        <= n_bip;
            r_pix_done   <= n_pix_done;
            r_bytes_done <= n_bytes_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_sub   <= '0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
            r_s1_sub   <= '0;
        end else if (s1_step) begin
            r_s1_sub <= r_s1_sub + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_s1_type <= i_s_axis_tuser;
            r_s1_slot <= i_s_axis_tdata[7:0];
            r_s1_word <= i_s_axis_tdata[39:8];
            r_s1_byte <= i_s_axis_tdata[47:40];
        end
    end

    // colour table, one write and one registered read port
    assign pal_we = s1_step && !is_pix && ({1'b0, r_s1_slot} < 9'(PALETTE_ENTRIES));
    assign rd_en  = load_en && indexed;

    always_ff @(posedge i_clk) begin
        if (pal_we) r_pal_mem[r_s1_slot[AW-1:0]] <= r_s1_word;
        if (rd_en)  r_rd_data <= r_pal_mem[pal_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load_ok) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_out_ind      <= indexed;
            r_out_zero     <= idx_oob;
            r_out_direct   <= direct_rgba;
            r_out_row_end  <= row_last;
            r_out_run_last <= !indexed || sub_last || row_last;
        end
    end

    // table word is blue, green, red, alpha from the low byte up
    assign pal_rgba = {r_rd_data[31:24], r_rd_data[7:0], r_rd_data[15:8], r_rd_data[23:16]};

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = !r_out_ind ? r_out_direct : (r_out_zero ? '0 : pal_rgba);
    assign o_m_axis_tlast  = r_out_row_end;
    assign o_m_axis_tuser  = r_out_run_last;

    a_pix_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix_done <= eff_w)
        else $error("pixel count ran past row width");

    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && indexed) |-> (r_s1_sub <= per_m1))
        else $error("pixel step beyond pixels per byte");

    a_palette_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !is_pix) |=> !($past(out_load_ok) && r_out_valid && !$past(emit)) ||
        !r_out_valid)
        else $error("palette write produced a pixel");

    a_cfg_clears_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_row_clr |=> (r_pix_done == '0 && r_bytes_done == '0 && r_bip == '0))
        else $error("row position not cleared by format or width write");

    a_bip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bip <= nb_m1)
        else $error("byte position in pixel out of range");

endmodule
